>>> rtl/lsfd_pkg.sv
// Shared constants, types and codes of the lidar scan frame deframer.
`timescale 1ns / 1ps

package lsfd_pkg;

  // Frame geometry.
  localparam int SAMPLES_PER_FRAME = 16;
  localparam int FRAME_BYTES       = 60;

  // Widths that follow from the geometry.
  localparam int ADDR_W  = $clog2(FRAME_BYTES);
  localparam int CNT_W   = $clog2(FRAME_BYTES + 1);
  localparam int SADDR_W = $clog2(3 * SAMPLES_PER_FRAME + 8);
  localparam int K_W     = $clog2(SAMPLES_PER_FRAME);

  // Header and frame layout.
  localparam logic [7:0] HDR0       = 8'h55;
  localparam logic [7:0] HDR1       = 8'hAA;
  localparam logic [7:0] FRAME_TYPE = 8'h23;
  localparam int TYPE_IDX     = 2;
  localparam int COUNT_IDX    = 3;
  localparam int SPEED_LO_IDX = 4;
  localparam int SPEED_HI_IDX = 5;
  localparam int START_LO_IDX = 6;
  localparam int START_HI_IDX = 7;
  localparam int SAMPLE_BASE  = 8;
  localparam int END_IDX      = SAMPLE_BASE + 3 * SAMPLES_PER_FRAME;

  // Angle arithmetic, in 1/64 degree.
  localparam logic [15:0]        ANGLE_BIAS = 16'h2000;
  localparam logic signed [17:0] FULL_TURN  = 18'sd23040;

  // Distance divided by ten: reciprocal multiply, exact for 14-bit values.
  localparam logic [14:0] DIST_RECIP = 15'd26215;
  localparam int          DIST_SHIFT = 18;

  // Angle step divided by the sample count less one.
  localparam int STEP_DIV     = SAMPLES_PER_FRAME - 1;
  localparam int STEP_X_W     = 24;
  localparam int STEP_SHIFT   = STEP_X_W + $clog2(STEP_DIV);
  localparam int STEP_RECIP_W = STEP_X_W + 1;
  localparam int STEP_PROD_W  = STEP_X_W + STEP_RECIP_W;
  localparam longint unsigned STEP_RECIP =
    ((64'd1 << STEP_SHIFT) + 64'(STEP_DIV) - 64'd1) / 64'(STEP_DIV);
  localparam int STEP_W = 22;
  localparam logic [STEP_RECIP_W-1:0] STEP_POS_LIM = STEP_RECIP_W'(2097151);
  localparam logic [STEP_RECIP_W-1:0] STEP_NEG_LIM = STEP_RECIP_W'(2097152);
  localparam logic signed [STEP_W-1:0] STEP_MAX = 22'sh1FFFFF;
  localparam logic signed [STEP_W-1:0] STEP_MIN = 22'sh200000;

  // Header hunt phase.
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SEEN,
    PH_COLLECT
  } sync_phase_t;

  // Sample readout sequence.
  typedef enum logic [2:0] {
    RD_IDLE,
    RD_LO,
    RD_HI,
    RD_ST,
    RD_CALC,
    RD_LOAD,
    RD_OUT
  } rd_state_t;

  // Write port into the frame store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  // Header words picked up while the frame streams in.
  typedef struct packed {
    logic [15:0] speed;
    logic [14:0] start_raw;
    logic [14:0] end_raw;
  } frame_hdr_t;

endpackage

>>> rtl/lidar_scan_frame_deframer.sv
// Top level of the lidar scan frame deframer.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+----------------------------------------
//   in      | input     | in_valid / in_ready  | in_byte
//   out     | output    | out_valid / out_ready| sample_index, distance, flag_bits,
//           |           |                      | strength, frame_angle, angle_step,
//           |           |                      | rotation_speed, last_sample
//
// A byte is taken whenever in_valid is high while hunting for the header or collecting the frame.
// After the last byte of a frame with the right type and count, input stalls while the
// samples are read out, one after another, each with three reads through the single
// read port of the frame store, and for as long as out_ready is low.
// Frames of other types or counts give no results and do not stall the input.
// Reset (synchronous) returns to header hunting; the frame store needs no clearing.
`timescale 1ns / 1ps

module lidar_scan_frame_deframer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [3:0]                         sample_index,
  output logic [10:0]                        distance,
  output logic [1:0]                         flag_bits,
  output logic [7:0]                         strength,
  output logic [15:0]                        frame_angle,
  output logic signed [lsfd_pkg::STEP_W-1:0] angle_step,
  output logic [15:0]                        rotation_speed,
  output logic                               last_sample
);

  lsfd_pkg::mem_wr_t                  wr;
  lsfd_pkg::frame_hdr_t               hdr;
  logic                               frame_done;
  logic                               frame_ok;
  logic                               busy;
  logic [15:0]                        scan_angle;
  logic [15:0]                        frame_speed;
  logic signed [lsfd_pkg::STEP_W-1:0] frame_step;

  // Input is held off while a frame's samples are being delivered.
  assign in_ready = !busy;

  lsfd_sync u_sync (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .wr         (wr),
    .hdr        (hdr),
    .frame_done (frame_done),
    .frame_ok   (frame_ok)
  );

  lsfd_step u_step (
    .clk            (clk),
    .rst            (rst),
    .frame_done     (frame_done),
    .hdr            (hdr),
    .scan_angle     (scan_angle),
    .rotation_speed (frame_speed),
    .angle_step     (frame_step)
  );

  lsfd_readout u_readout (
    .clk               (clk),
    .rst               (rst),
    .wr                (wr),
    .start             (frame_done && frame_ok),
    .scan_angle        (scan_angle),
    .frame_speed       (frame_speed),
    .frame_step        (frame_step),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .sample_index      (sample_index),
    .distance          (distance),
    .flag_bits         (flag_bits),
    .strength          (strength),
    .frame_angle       (frame_angle),
    .angle_step        (angle_step),
    .rotation_speed    (rotation_speed),
    .last_sample       (last_sample)
  );

endmodule

>>> rtl/lsfd_sync.sv
// Header hunt, byte counter and frame store write port of the deframer.
`timescale 1ns / 1ps

module lsfd_sync (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [7:0]          in_byte,
  output lsfd_pkg::mem_wr_t   wr,
  output lsfd_pkg::frame_hdr_t hdr,
  output logic                frame_done,
  output logic                frame_ok
);

  lsfd_pkg::sync_phase_t            phase, phase_next;
  logic [lsfd_pkg::CNT_W-1:0]       count, count_next;
  logic                             accept;
  logic                             last_byte;
  logic [7:0] type_b, cnt_b, spd_lo, spd_hi, st_lo, st_hi, end_lo_q, end_hi_q;
  logic [7:0] end_lo, end_hi;

  assign accept    = in_valid && in_ready;
  assign last_byte = (count == lsfd_pkg::CNT_W'(lsfd_pkg::FRAME_BYTES - 1));

  // Next phase and byte count.
  always_comb begin
    phase_next = phase;
    count_next = count;
    if (accept) begin
      case (phase)
        lsfd_pkg::PH_COLLECT: begin
          if (last_byte) begin
            phase_next = lsfd_pkg::PH_HUNT;
            count_next = '0;
          end else begin
            count_next = count + 1'b1;
          end
        end
        lsfd_pkg::PH_SEEN: begin
          if (in_byte == lsfd_pkg::HDR1) begin
            phase_next = lsfd_pkg::PH_COLLECT;
            count_next = lsfd_pkg::CNT_W'(2);
          end else if (in_byte == lsfd_pkg::HDR0) begin
            phase_next = lsfd_pkg::PH_SEEN;
          end else begin
            phase_next = lsfd_pkg::PH_HUNT;
          end
        end
        default: begin
          phase_next = (in_byte == lsfd_pkg::HDR0) ? lsfd_pkg::PH_SEEN : lsfd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // Store writes and the end-of-frame pulse.
  always_comb begin
    wr.en      = accept && (phase == lsfd_pkg::PH_COLLECT);
    wr.addr    = count[lsfd_pkg::ADDR_W-1:0];
    wr.data    = in_byte;
    frame_done = wr.en && last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lsfd_pkg::PH_HUNT;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  // Pick up the header bytes as they are written.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (count == lsfd_pkg::CNT_W'(lsfd_pkg::TYPE_IDX))     type_b <= in_byte;
      if (count == lsfd_pkg::CNT_W'(lsfd_pkg::COUNT_IDX))    cnt_b  <= in_byte;
      if (count == lsfd_pkg::CNT_W'(lsfd_pkg::SPEED_LO_IDX)) spd_lo <= in_byte;
      if (count == lsfd_pkg::CNT_W'(lsfd_pkg::SPEED_HI_IDX)) spd_hi <= in_byte;
      if (count == lsfd_pkg::CNT_W'(lsfd_pkg::START_LO_IDX)) st_lo  <= in_byte;
      if (count == lsfd_pkg::CNT_W'(lsfd_pkg::START_HI_IDX)) st_hi  <= in_byte;
      if ((lsfd_pkg::END_IDX < lsfd_pkg::FRAME_BYTES) &&
          (count == lsfd_pkg::CNT_W'(lsfd_pkg::END_IDX))) begin
        end_lo_q <= in_byte;
      end
      if ((lsfd_pkg::END_IDX + 1 < lsfd_pkg::FRAME_BYTES) &&
          (count == lsfd_pkg::CNT_W'(lsfd_pkg::END_IDX + 1))) begin
        end_hi_q <= in_byte;
      end
    end
  end

  // An end angle placed beyond the frame reads as zero.
  assign end_lo = (lsfd_pkg::END_IDX < lsfd_pkg::FRAME_BYTES) ? end_lo_q : 8'h00;
  assign end_hi = (lsfd_pkg::END_IDX + 1 < lsfd_pkg::FRAME_BYTES) ? end_hi_q : 8'h00;

  always_comb begin
    hdr.speed     = {spd_hi, spd_lo};
    hdr.start_raw = {st_hi[6:0], st_lo};
    hdr.end_raw   = {end_hi[6:0], end_lo};
  end

  assign frame_ok = (type_b == lsfd_pkg::FRAME_TYPE) &&
                    (cnt_b == 8'(lsfd_pkg::SAMPLES_PER_FRAME));

endmodule

>>> rtl/lsfd_step.sv
// Start angle and per-sample angle step of a completed frame.
`timescale 1ns / 1ps

module lsfd_step (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 frame_done,
  input  lsfd_pkg::frame_hdr_t                 hdr,
  output logic [15:0]                          scan_angle,
  output logic [15:0]                          rotation_speed,
  output logic signed [lsfd_pkg::STEP_W-1:0]   angle_step
);

  localparam logic [lsfd_pkg::STEP_RECIP_W-1:0] RECIP =
    lsfd_pkg::STEP_RECIP_W'(lsfd_pkg::STEP_RECIP);

  logic                                go1, go2, go3;
  logic [15:0]                         start16, end16;
  logic signed [17:0]                  diff;
  logic [17:0]                         mag;
  logic [lsfd_pkg::STEP_X_W-1:0]       x;
  logic                                neg1, neg2;
  logic [lsfd_pkg::STEP_PROD_W-1:0]    prod;
  logic [lsfd_pkg::STEP_RECIP_W-1:0]   quot;

  // Header bytes are final by the last byte; the chain starts in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      go1 <= 1'b0;
      go2 <= 1'b0;
      go3 <= 1'b0;
    end else begin
      go1 <= frame_done;
      go2 <= go1;
      go3 <= go2;
    end
  end

  // Angle difference, wrapped by a full turn when the end lies below the start.
  always_comb begin
    start16 = 16'({1'b0, hdr.start_raw}) - lsfd_pkg::ANGLE_BIAS;
    end16   = 16'({1'b0, hdr.end_raw}) - lsfd_pkg::ANGLE_BIAS;
    diff    = $signed({2'b00, end16}) - $signed({2'b00, start16}) +
              ((end16 < start16) ? lsfd_pkg::FULL_TURN : 18'sd0);
    mag     = diff[17] ? 18'(-diff) : 18'(diff);
    quot    = lsfd_pkg::STEP_RECIP_W'(prod >> lsfd_pkg::STEP_SHIFT);
  end

  // Stage one: magnitude scaled by 256, sign kept aside, start angle and speed latched.
  always_ff @(posedge clk) begin
    if (go1) begin
      x              <= {mag[15:0], 8'h00};
      neg1           <= diff[17];
      scan_angle     <= start16;
      rotation_speed <= hdr.speed;
    end
  end

  // Stage two: reciprocal multiply stands in for the division.
  always_ff @(posedge clk) begin
    if (go2) begin
      prod <= x * RECIP;
      neg2 <= neg1;
    end
  end

  // Stage three: shift, restore the sign and saturate.
  always_ff @(posedge clk) begin
    if (go3) begin
      if (!neg2) begin
        angle_step <= (quot > lsfd_pkg::STEP_POS_LIM) ? lsfd_pkg::STEP_MAX :
                      $signed(quot[lsfd_pkg::STEP_W-1:0]);
      end else begin
        angle_step <= (quot > lsfd_pkg::STEP_NEG_LIM) ? lsfd_pkg::STEP_MIN :
                      -$signed(quot[lsfd_pkg::STEP_W-1:0]);
      end
    end
  end

endmodule

>>> rtl/lsfd_readout.sv
// Frame store and the sample readout sequencer with its output register.
`timescale 1ns / 1ps

module lsfd_readout (
  input  logic                               clk,
  input  logic                               rst,
  input  lsfd_pkg::mem_wr_t                  wr,
  input  logic                               start,
  input  logic [15:0]                        scan_angle,
  input  logic [15:0]                        frame_speed,
  input  logic signed [lsfd_pkg::STEP_W-1:0] frame_step,
  output logic                               busy,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [3:0]                         sample_index,
  output logic [10:0]                        distance,
  output logic [1:0]                         flag_bits,
  output logic [7:0]                         strength,
  output logic [15:0]                        frame_angle,
  output logic signed [lsfd_pkg::STEP_W-1:0] angle_step,
  output logic [15:0]                        rotation_speed,
  output logic                               last_sample
);

  lsfd_pkg::rd_state_t              state, state_next;
  logic [7:0]                       mem [lsfd_pkg::FRAME_BYTES];
  logic [lsfd_pkg::SADDR_W-1:0]     rd_addr, base;
  logic [7:0]                       rd_data, byte_in;
  logic                             rd_oob;
  logic [lsfd_pkg::K_W-1:0]         k;
  logic                             k_last;
  logic [7:0]                       lo, hi, st;
  logic [13:0]                      raw;
  logic [28:0]                      prod;

  assign k_last = (k == lsfd_pkg::K_W'(lsfd_pkg::SAMPLES_PER_FRAME - 1));
  assign raw    = {hi[5:0], lo};

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[lsfd_pkg::ADDR_W'(rd_addr)];
    rd_oob  <= (int'(rd_addr) >= lsfd_pkg::FRAME_BYTES);
  end

  // Bytes placed beyond the frame read as zero.
  assign byte_in = rd_oob ? 8'h00 : rd_data;

  // Next state of the readout sequence.
  always_comb begin
    state_next = state;
    case (state)
      lsfd_pkg::RD_IDLE: if (start) state_next = lsfd_pkg::RD_LO;
      lsfd_pkg::RD_LO:   state_next = lsfd_pkg::RD_HI;
      lsfd_pkg::RD_HI:   state_next = lsfd_pkg::RD_ST;
      lsfd_pkg::RD_ST:   state_next = lsfd_pkg::RD_CALC;
      lsfd_pkg::RD_CALC: state_next = lsfd_pkg::RD_LOAD;
      lsfd_pkg::RD_LOAD: state_next = lsfd_pkg::RD_OUT;
      lsfd_pkg::RD_OUT: begin
        if (out_ready) begin
          state_next = k_last ? lsfd_pkg::RD_IDLE : lsfd_pkg::RD_LO;
        end
      end
      default: state_next = lsfd_pkg::RD_IDLE;
    endcase
  end

  // Read address, busy flag and output valid.
  always_comb begin
    case (state)
      lsfd_pkg::RD_HI: rd_addr = base + lsfd_pkg::SADDR_W'(1);
      lsfd_pkg::RD_ST: rd_addr = base + lsfd_pkg::SADDR_W'(2);
      default:         rd_addr = base;
    endcase
    busy      = (state != lsfd_pkg::RD_IDLE);
    out_valid = (state == lsfd_pkg::RD_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsfd_pkg::RD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sample datapath: gather three bytes, divide the distance, load the result.
  always_ff @(posedge clk) begin
    case (state)
      lsfd_pkg::RD_IDLE: begin
        if (start) begin
          k    <= '0;
          base <= lsfd_pkg::SADDR_W'(lsfd_pkg::SAMPLE_BASE);
        end
      end
      lsfd_pkg::RD_HI: lo <= byte_in;
      lsfd_pkg::RD_ST: hi <= byte_in;
      lsfd_pkg::RD_CALC: begin
        st   <= byte_in;
        prod <= raw * lsfd_pkg::DIST_RECIP;
      end
      lsfd_pkg::RD_LOAD: begin
        sample_index   <= 4'(k);
        distance       <= (st == 8'h00) ? 11'd0 : prod[lsfd_pkg::DIST_SHIFT +: 11];
        flag_bits      <= hi[7:6];
        strength       <= st;
        frame_angle    <= scan_angle;
        angle_step     <= frame_step;
        rotation_speed <= frame_speed;
        last_sample    <= k_last;
      end
      lsfd_pkg::RD_OUT: begin
        if (out_ready) begin
          k    <= k + 1'b1;
          base <= base + lsfd_pkg::SADDR_W'(3);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/lsfd_checker.sv
// Port-level assertions for the deframer and the bind that attaches them.
`timescale 1ns / 1ps

module lsfd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [3:0]                         sample_index,
  input logic [10:0]                        distance,
  input logic [7:0]                         strength,
  input logic signed [lsfd_pkg::STEP_W-1:0] angle_step,
  input logic                               last_sample
);

  // No byte is taken while a sample waits at the output.
  a_no_input_during_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a sample is pending");

  // A stalled sample holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_index) &&
                                   $stable(distance) && $stable(angle_step)))
    else $error("output sample changed while stalled");

  // Input stays blocked between samples of one frame.
  a_busy_mid_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_sample) |=> !in_ready)
    else $error("input reopened before the frame was fully delivered");

  // A return with no strength reports no distance.
  a_zero_strength: assert property (@(posedge clk) disable iff (rst)
    (out_valid && strength == 8'd0) |-> distance == 11'd0)
    else $error("distance given for a zero-strength return");

  // The final sample of a frame carries the last index.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_sample) |->
      sample_index == 4'(lsfd_pkg::SAMPLES_PER_FRAME - 1))
    else $error("last sample flagged at the wrong index");

endmodule

bind lidar_scan_frame_deframer lsfd_checker u_lsfd_checker (.*);
